>>> hdl/fsts_pkg.sv
// Package for the fair-share task scheduler: request and result types,
// slot entry layout, status codes and register indexes. No dependencies.
package fsts_pkg;

  localparam int unsigned WEIGHT_MAX = 88761;

  // status codes of a result
  localparam logic [2:0] ST_RAN      = 3'd0;
  localparam logic [2:0] ST_FINISHED = 3'd1;
  localparam logic [2:0] ST_NO_TASK  = 3'd2;
  localparam logic [2:0] ST_ADDED    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // request kinds
  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_RUN = 1'b1;

  // register indexes
  localparam logic [1:0] REG_LATENCY   = 2'd0;
  localparam logic [1:0] REG_MIN_SLICE = 2'd1;
  localparam logic [1:0] REG_NOMINAL   = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [15:0] task_id;
    logic [16:0] task_weight;
    logic [23:0] run_time;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] chosen_id;
    logic [23:0] slice_ms;
    logic [23:0] executed_ms;
    logic [47:0] virtual_runtime;
    logic [4:0]  tasks_left;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [16:0] weight;
    logic [47:0] vruntime;
    logic [23:0] remaining;
    logic [23:0] executed;
  } entry_t;

endpackage

>>> hdl/fair_share_task_scheduler_unit.sv
// Top level of the fair-share task scheduler: slot table, sequencer and
// configuration registers. Depends on fsts_pkg and fsts_div.
//
// One request is taken at a time; in_ready is high while the sequencer is
// idle. An add request walks the valid bits one slot a cycle until it finds
// a free slot. A run request scans the slot memory, reading (S_RD) and then
// comparing (S_CMP) each slot. It then runs two divisions on the shared
// divider, 64 quotient bits each, with a set-up state before each, then an
// update state and an output state. The next request is accepted while a
// result waits in the output register.
module fair_share_task_scheduler_unit #(
  parameter int TASKS          = 16,
  parameter int VRUN_FRAC_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fsts_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output fsts_pkg::out_t out_data,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [3:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int TW = $clog2(TASKS * fsts_pkg::WEIGHT_MAX + 1);
  localparam int CW = $clog2(TASKS + 1);
  localparam int DW = 64;
  localparam logic [64:0] MASK48 = {17'd0, {48{1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE, S_FREE, S_RD, S_CMP, S_MUL1, S_DIV1, S_MUL2, S_DIV2, S_UPD, S_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [19:0] latency_r;
  logic [16:0] min_slice_r;
  logic [16:0] nominal_r;
  logic [1:0]  reg_idx;

  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latency_r   <= 20'd48;
      min_slice_r <= 17'd4;
      nominal_r   <= 17'd1024;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      case (reg_idx)
        fsts_pkg::REG_LATENCY:   latency_r   <= cfg_pwdata[19:0];
        fsts_pkg::REG_MIN_SLICE: min_slice_r <= cfg_pwdata[16:0];
        fsts_pkg::REG_NOMINAL:   nominal_r   <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fsts_pkg::REG_LATENCY:   cfg_prdata = {12'd0, latency_r};
      fsts_pkg::REG_MIN_SLICE: cfg_prdata = {15'd0, min_slice_r};
      fsts_pkg::REG_NOMINAL:   cfg_prdata = {15'd0, nominal_r};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  // request, scan and arithmetic registers
  logic [TASKS-1:0]   valid_r;
  logic [TW-1:0]      total_r;
  logic [CW-1:0]      count_r;
  fsts_pkg::in_t      req_r;
  logic [IW-1:0]      idx_r;
  logic [IW-1:0]      best_idx_r;
  logic               have_r;
  fsts_pkg::entry_t   best_r;
  logic [DW-1:0]      dvd_r;
  logic [TW-1:0]      dvs_r;
  logic [23:0]        slice_r;
  logic               div_start_r;
  logic               div_done;
  logic [DW-1:0]      quot;
  logic               out_valid_r;
  fsts_pkg::out_t     res_r;
  fsts_pkg::out_t     out_r;

  // slot memory, one write and one registered read port
  fsts_pkg::entry_t mem [TASKS];
  fsts_pkg::entry_t rd_data_r;
  fsts_pkg::entry_t wr_data;
  logic [IW-1:0]    wr_addr;
  logic             wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[idx_r];
  end

  fsts_div #(.DW(DW), .VW(TW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (dvd_r),
    .divisor  (dvs_r),
    .done     (div_done),
    .quotient (quot)
  );

  // clamped weight of an added task
  logic [16:0] add_w;
  always_comb begin
    add_w = req_r.task_weight;
    if (add_w == 17'd0) add_w = 17'd1;
    if (add_w > 17'(fsts_pkg::WEIGHT_MAX)) add_w = 17'(fsts_pkg::WEIGHT_MAX);
  end

  // dividends: latency times weight, slice times nominal weight
  logic [36:0] lat_prod;
  logic [40:0] nom_prod;
  always_comb begin
    lat_prod = {17'd0, latency_r} * {20'd0, best_r.weight};
    nom_prod = {17'd0, slice_r} * {24'd0, nominal_r};
  end

  // slice clamping against min slice and remaining time
  logic [DW-1:0] slice_min;
  logic [23:0]   slice_cap;
  always_comb begin
    slice_min = (quot < {{(DW-17){1'b0}}, min_slice_r}) ?
                {{(DW-17){1'b0}}, min_slice_r} : quot;
    slice_cap = (slice_min > {{(DW-24){1'b0}}, best_r.remaining}) ?
                best_r.remaining : slice_min[23:0];
  end

  // update of the chosen slot
  logic [64:0] vr_sum;
  logic [47:0] vr_new;
  logic [24:0] ex_sum;
  logic [23:0] ex_new;
  logic [23:0] rem_new;
  logic [TW-1:0] w_ext;
  always_comb begin
    vr_sum  = {17'd0, best_r.vruntime} + {1'b0, quot};
    vr_new  = (vr_sum > MASK48) ? {48{1'b1}} : vr_sum[47:0];
    ex_sum  = {1'b0, best_r.executed} + {1'b0, slice_r};
    ex_new  = ex_sum[24] ? {24{1'b1}} : ex_sum[23:0];
    rem_new = best_r.remaining - slice_r;
    w_ext   = TW'(best_r.weight);
  end

  // memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = '0;
    if (state_r == S_FREE && !valid_r[idx_r]) begin
      wr_en   = 1'b1;
      wr_data = '{id: req_r.task_id, weight: add_w, vruntime: 48'd0,
                  remaining: req_r.run_time, executed: 24'd0};
    end else if (state_r == S_UPD) begin
      wr_en   = 1'b1;
      wr_addr = best_idx_r;
      wr_data = '{id: best_r.id, weight: best_r.weight, vruntime: vr_new,
                  remaining: rem_new, executed: ex_new};
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      total_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= (state_r == S_MUL1) || (state_r == S_MUL2);
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            idx_r   <= '0;
            have_r  <= 1'b0;
            state_r <= (in_data.kind == fsts_pkg::KIND_ADD) ? S_FREE : S_RD;
          end
        end
        S_FREE: begin
          if (!valid_r[idx_r]) begin
            valid_r[idx_r] <= 1'b1;
            total_r        <= total_r + TW'(add_w);
            count_r        <= count_r + 1'b1;
            res_r   <= '{status: fsts_pkg::ST_ADDED, chosen_id: req_r.task_id,
                         slice_ms: 24'd0, executed_ms: 24'd0,
                         virtual_runtime: 48'd0, tasks_left: 5'(count_r + 1'b1)};
            state_r <= S_OUT;
          end else if (idx_r == IW'(TASKS - 1)) begin
            res_r   <= '{status: fsts_pkg::ST_FULL, chosen_id: req_r.task_id,
                         slice_ms: 24'd0, executed_ms: 24'd0,
                         virtual_runtime: 48'd0, tasks_left: 5'(count_r)};
            state_r <= S_OUT;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          if (valid_r[idx_r] && (!have_r || rd_data_r.vruntime < best_r.vruntime)) begin
            have_r     <= 1'b1;
            best_r     <= rd_data_r;
            best_idx_r <= idx_r;
          end
          if (idx_r == IW'(TASKS - 1)) begin
            if (!have_r && !valid_r[idx_r]) begin
              res_r   <= '{status: fsts_pkg::ST_NO_TASK, chosen_id: 16'd0,
                           slice_ms: 24'd0, executed_ms: 24'd0,
                           virtual_runtime: 48'd0, tasks_left: 5'd0};
              state_r <= S_OUT;
            end else begin
              state_r <= S_MUL1;
            end
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_MUL1: begin
          dvd_r   <= {{(DW-37){1'b0}}, lat_prod};
          dvs_r   <= (total_r < w_ext) ? w_ext : total_r;
          state_r <= S_DIV1;
        end
        S_DIV1: begin
          if (div_done) begin
            slice_r <= slice_cap;
            state_r <= S_MUL2;
          end
        end
        S_MUL2: begin
          dvd_r   <= {{(DW-41){1'b0}}, nom_prod} << VRUN_FRAC_BITS;
          dvs_r   <= w_ext;
          state_r <= S_DIV2;
        end
        S_DIV2: if (div_done) state_r <= S_UPD;
        S_UPD: begin
          if (rem_new == 24'd0) begin
            valid_r[best_idx_r] <= 1'b0;
            total_r <= (total_r >= w_ext) ? total_r - w_ext : '0;
            if (count_r != '0) count_r <= count_r - 1'b1;
            res_r <= '{status: fsts_pkg::ST_FINISHED, chosen_id: best_r.id,
                       slice_ms: slice_r, executed_ms: ex_new,
                       virtual_runtime: vr_new,
                       tasks_left: 5'((count_r != '0) ? count_r - 1'b1 : count_r)};
          end else begin
            res_r <= '{status: fsts_pkg::ST_RAN, chosen_id: best_r.id,
                       slice_ms: slice_r, executed_ms: ex_new,
                       virtual_runtime: vr_new, tasks_left: 5'(count_r)};
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hdl/fsts_div.sv
// Restoring divider for the fair-share task scheduler, one quotient bit
// per cycle. Depends on nothing.
module fsts_div #(
  parameter int DW = 64,
  parameter int VW = 21
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW);

  logic [VW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   quot_r, quot_nxt;
  logic [VW-1:0]   dvs_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r;
  logic [VW:0]     trial;
  logic [VW:0]     diff;

  // one shift-subtract step
  always_comb begin
    trial    = {rem_r, quot_r[DW-1]};
    diff     = trial - {1'b0, dvs_r};
    quot_nxt = {quot_r[DW-2:0], ~diff[VW]};
    rem_nxt  = diff[VW] ? trial[VW-1:0] : diff[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quot_r <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        quot_r <= quot_nxt;
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule
